@@ src/fpba_pkg.sv @@
// Shared types and codes of the fit-policy block allocator.
package fpba_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int LEN_BITS    = OFFSET_BITS + 1;

    localparam logic [1:0] KIND_INIT  = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] POL_RSVD  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_NOTALLOC = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_REGION = 1'b1;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_CLOSE  = 9'b000001000,
        S_USHIFT = 9'b000010000,
        S_FSCAN  = 9'b000100000,
        S_FCLOSE = 9'b001000000,
        S_FSHIFT = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

endpackage

@@ src/fit_policy_block_allocator.sv @@
// Top level of the fit-policy block allocator.
// The allocator keeps a free-block table and a used-block table, each in one
// synchronous memory (registered read) holding start and length per
// entry. An init request frees the whole region as one block. An allocate
// scans the free table one entry per cycle (first fit stops at the first
// block large enough), then, on success, closes the gap of an exact fit one
// entry per cycle and shifts the used table one entry per cycle to open its
// front slot. A free scans the used table, closes the gap there and shifts
// the free table. The single read port of each table memory sets the cost
// of the scans and shifts. One request is worked on at a time; the result
// waits in an output register and the next request is taken only in a cycle
// where no result waits or the waiting result leaves.
module fit_policy_block_allocator #(
    parameter int FREE_ENTRIES = 32,
    parameter int USED_ENTRIES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [fpba_pkg::LEN_BITS-1:0]    i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_kind,
    input  logic [fpba_pkg::LEN_BITS-1:0]    i_request_size,
    input  logic [fpba_pkg::OFFSET_BITS-1:0] i_block_offset,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_status,
    output logic [fpba_pkg::OFFSET_BITS-1:0] o_address
);
    localparam int FW = $clog2(FREE_ENTRIES);
    localparam int UW = $clog2(USED_ENTRIES);
    localparam int IW = (FW > UW) ? FW : UW;
    localparam int OB = fpba_pkg::OFFSET_BITS;
    localparam int LW = fpba_pkg::LEN_BITS;
    localparam logic [LW-1:0] LEN_LIMIT = {1'b1, {OB{1'b0}}};

    // table memories: {start, length}
    logic [OB+LW-1:0] free_mem [FREE_ENTRIES];
    logic [OB+LW-1:0] used_mem [USED_ENTRIES];
    logic [OB+LW-1:0] r_frd, r_urd;

    logic [1:0]    r_policy;
    logic [LW-1:0] r_region;

    fpba_pkg::t_state r_state, n_state;
    logic [FW:0] r_fcnt, n_fcnt;
    logic [UW:0] r_ucnt, n_ucnt;
    logic [IW:0] r_idx, n_idx;        // issued read index (shared by scans)
    logic [IW:0] r_ptr, n_ptr;        // index of data now on the read port (one above it in the shift states)
    logic        r_rdv, n_rdv;
    logic        r_found, n_found;
    logic [IW:0] r_pick, n_pick;
    logic [LW-1:0] r_plen, n_plen;
    logic [OB-1:0] r_pstart, n_pstart;
    logic [1:0]    r_kind;
    logic [LW-1:0] r_size;
    logic [OB-1:0] r_ofs;
    logic [OB-1:0] r_nstart, n_nstart;
    logic [LW-1:0] r_nlen, n_nlen;
    logic          r_ov, n_ov;
    logic [1:0]    r_st, n_st;
    logic [OB-1:0] r_addr, n_addr;

    // memory ports
    logic             f_we, u_we;
    logic [FW-1:0]    f_wa, f_ra;
    logic [UW-1:0]    u_wa, u_ra;
    logic [OB+LW-1:0] f_wd, u_wd;

    logic accept;
    assign o_stall = (r_state != fpba_pkg::S_IDLE) || (r_ov && i_stall);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_ov;
    assign o_status = r_st;
    assign o_address = r_addr;

    logic [LW-1:0] flen, ulen;
    logic [OB-1:0] fst, ust;
    assign flen = r_frd[LW-1:0];
    assign fst  = r_frd[OB+LW-1:LW];
    assign ulen = r_urd[LW-1:0];
    assign ust  = r_urd[OB+LW-1:LW];

    // saturate the region to the offset range
    logic [LW-1:0] reg_len;
    assign reg_len = (r_region > LEN_LIMIT) ? LEN_LIMIT : r_region;

    always_ff @(posedge i_clk) begin
        if (f_we) free_mem[f_wa] <= f_wd;
        r_frd <= free_mem[f_ra];
        if (u_we) used_mem[u_wa] <= u_wd;
        r_urd <= used_mem[u_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= fpba_pkg::POL_FIRST;
            r_region <= LEN_LIMIT;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fpba_pkg::CFG_POLICY) r_policy <= i_cfg_data[1:0];
            else r_region <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_size <= i_request_size;
            r_ofs  <= i_block_offset;
        end
    end

    always_comb begin
        n_state = r_state; n_fcnt = r_fcnt; n_ucnt = r_ucnt;
        n_idx = r_idx; n_ptr = r_idx; n_rdv = 1'b0;
        n_found = r_found; n_pick = r_pick; n_plen = r_plen; n_pstart = r_pstart;
        n_nstart = r_nstart; n_nlen = r_nlen;
        n_ov = r_ov && i_stall; n_st = r_st; n_addr = r_addr;
        f_we = 1'b0; u_we = 1'b0;
        f_wa = r_idx[FW-1:0]; u_wa = r_idx[UW-1:0];
        f_wd = '0; u_wd = '0;
        f_ra = r_idx[FW-1:0]; u_ra = r_idx[UW-1:0];
        unique case (r_state)
            fpba_pkg::S_IDLE: begin
                n_idx = '0;
                n_found = 1'b0;
                if (accept) begin
                    unique case (i_kind)
                        fpba_pkg::KIND_INIT:  n_state = fpba_pkg::S_DONE;
                        fpba_pkg::KIND_ALLOC: n_state = fpba_pkg::S_SCAN;
                        fpba_pkg::KIND_FREE:  n_state = fpba_pkg::S_FSCAN;
                        fpba_pkg::KIND_RSVD:  n_state = fpba_pkg::S_DONE;
                    endcase
                    n_st = fpba_pkg::ST_OK;
                end
            end
            // issue one read a cycle, evaluate the entry that comes back
            fpba_pkg::S_SCAN: begin
                f_ra = r_idx[FW-1:0];
                if (r_idx < (IW+1)'(r_fcnt)) begin
                    n_idx = r_idx + 1'b1; n_rdv = 1'b1;
                end
                if (r_rdv && flen >= r_size && r_size != '0) begin
                    if (!r_found
                        || (r_policy == fpba_pkg::POL_BEST && flen < r_plen)
                        || (r_policy == fpba_pkg::POL_WORST && flen > r_plen)) begin
                        n_found = 1'b1; n_pick = r_ptr; n_plen = flen; n_pstart = fst;
                    end
                    if (!r_found && r_policy != fpba_pkg::POL_BEST
                        && r_policy != fpba_pkg::POL_WORST) begin
                        n_rdv = 1'b0; n_state = fpba_pkg::S_DECIDE;
                    end
                end
                if (!n_rdv) n_state = fpba_pkg::S_DECIDE;
            end
            fpba_pkg::S_DECIDE: begin
                if (!r_found) begin
                    n_st = fpba_pkg::ST_NOFIT; n_state = fpba_pkg::S_DONE;
                end else if (r_ucnt >= (UW+1)'(USED_ENTRIES)) begin
                    n_st = fpba_pkg::ST_FULL; n_state = fpba_pkg::S_DONE;
                end else begin
                    n_addr = r_pstart;
                    n_nstart = r_pstart; n_nlen = r_size;
                    if (r_plen == r_size) begin
                        n_idx = r_pick + 1'b1;
                        n_state = fpba_pkg::S_CLOSE;
                    end else begin
                        f_we = 1'b1; f_wa = r_pick[FW-1:0];
                        f_wd = {OB'(r_pstart + r_size[OB-1:0]), r_plen - r_size};
                        n_idx = (IW+1)'(r_ucnt);
                        n_state = fpba_pkg::S_USHIFT;
                    end
                end
            end
            // move entry idx down to idx-1 until the end of the table
            fpba_pkg::S_CLOSE: begin
                f_ra = r_idx[FW-1:0];
                if (r_rdv) begin
                    f_we = 1'b1; f_wa = FW'(r_ptr - 1'b1); f_wd = r_frd;
                end
                if (r_idx < (IW+1)'(r_fcnt)) begin
                    n_idx = r_idx + 1'b1; n_rdv = 1'b1;
                end else begin
                    n_fcnt = r_fcnt - 1'b1;
                    n_idx = (IW+1)'(r_ucnt);
                    n_state = fpba_pkg::S_USHIFT;
                end
            end
            // move used entries up from the back, then write the front
            fpba_pkg::S_USHIFT: begin
                u_ra = UW'(r_idx - 1'b1);
                if (r_rdv) begin
                    u_we = 1'b1; u_wa = UW'(r_ptr); u_wd = r_urd;
                end
                if (r_idx != '0) begin
                    n_idx = r_idx - 1'b1; n_ptr = r_idx; n_rdv = 1'b1;
                end else if (!r_rdv) begin
                    u_we = 1'b1; u_wa = '0; u_wd = {r_nstart, r_nlen};
                    n_ucnt = r_ucnt + 1'b1;
                    n_state = fpba_pkg::S_DONE;
                end
            end
            fpba_pkg::S_FSCAN: begin
                u_ra = r_idx[UW-1:0];
                if (r_idx < (IW+1)'(r_ucnt)) begin
                    n_idx = r_idx + 1'b1; n_rdv = 1'b1;
                end
                if (r_rdv && ust == r_ofs) begin
                    n_rdv = 1'b0;
                    if (r_fcnt >= (FW+1)'(FREE_ENTRIES)) begin
                        n_st = fpba_pkg::ST_FULL; n_state = fpba_pkg::S_DONE;
                    end else begin
                        n_nstart = ust; n_nlen = ulen;
                        n_idx = r_ptr + 1'b1;
                        n_state = fpba_pkg::S_FCLOSE;
                    end
                end else if (!n_rdv) begin
                    n_st = fpba_pkg::ST_NOTALLOC; n_state = fpba_pkg::S_DONE;
                end
            end
            fpba_pkg::S_FCLOSE: begin
                u_ra = r_idx[UW-1:0];
                if (r_rdv) begin
                    u_we = 1'b1; u_wa = UW'(r_ptr - 1'b1); u_wd = r_urd;
                end
                if (r_idx < (IW+1)'(r_ucnt)) begin
                    n_idx = r_idx + 1'b1; n_rdv = 1'b1;
                end else begin
                    n_ucnt = r_ucnt - 1'b1;
                    n_idx = (IW+1)'(r_fcnt);
                    n_state = fpba_pkg::S_FSHIFT;
                end
            end
            fpba_pkg::S_FSHIFT: begin
                f_ra = FW'(r_idx - 1'b1);
                if (r_rdv) begin
                    f_we = 1'b1; f_wa = FW'(r_ptr); f_wd = r_frd;
                end
                if (r_idx != '0) begin
                    n_idx = r_idx - 1'b1; n_ptr = r_idx; n_rdv = 1'b1;
                end else if (!r_rdv) begin
                    f_we = 1'b1; f_wa = '0; f_wd = {r_nstart, r_nlen};
                    n_fcnt = r_fcnt + 1'b1;
                    n_state = fpba_pkg::S_DONE;
                end
            end
            fpba_pkg::S_DONE: begin
                if (r_kind == fpba_pkg::KIND_INIT) begin
                    n_ucnt = '0;
                    n_fcnt = (reg_len != '0) ? (FW+1)'(1) : '0;
                    f_we = 1'b1; f_wa = '0; f_wd = {{OB{1'b0}}, reg_len};
                end
                if (n_st != fpba_pkg::ST_OK || r_kind != fpba_pkg::KIND_ALLOC)
                    n_addr = '0;
                n_ov = 1'b1;
                n_state = fpba_pkg::S_IDLE;
            end
            default: n_state = fpba_pkg::S_IDLE;
        endcase
        if (r_state == fpba_pkg::S_IDLE && accept) n_addr = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpba_pkg::S_IDLE;
            r_fcnt <= '0; r_ucnt <= '0; r_ov <= 1'b0; r_rdv <= 1'b0;
            r_found <= 1'b0; r_idx <= '0; r_ptr <= '0;
        end else begin
            r_state <= n_state; r_fcnt <= n_fcnt; r_ucnt <= n_ucnt;
            r_ov <= n_ov; r_rdv <= n_rdv; r_found <= n_found;
            r_idx <= n_idx; r_ptr <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pick <= n_pick; r_plen <= n_plen; r_pstart <= n_pstart;
        r_nstart <= n_nstart; r_nlen <= n_nlen; r_st <= n_st; r_addr <= n_addr;
    end

    // counts never exceed table depth
    a_fcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= (FW+1)'(FREE_ENTRIES)) else $error("free count overflow");
    a_ucnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ucnt <= (UW+1)'(USED_ENTRIES)) else $error("used count overflow");
    // a finished request always produces a result
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpba_pkg::S_DONE) |=> r_ov) else $error("result lost");
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_st != fpba_pkg::ST_OK) |-> r_addr == '0)
        else $error("address on failed request");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the fit-policy block allocator.
`timescale 1ns / 1ps

module testbench;

    localparam int N_FREE = 32;
    localparam int N_USED = 32;
    localparam logic [24:0] SPAN_MAX = 25'h1000000;
    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = fpba_pkg::CFG_POLICY;
    logic [24:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_kind = fpba_pkg::KIND_INIT;
    logic [24:0] i_request_size = '0;
    logic [23:0] i_block_offset = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [23:0] o_address;

    fit_policy_block_allocator dut (.*);

    always #5 i_clk = ~i_clk;

    // Allocator state as predicted from the accepted requests.
    logic [1:0]  policy;
    logic [24:0] region_len;
    logic [23:0] free_at [N_FREE];
    logic [24:0] free_len [N_FREE];
    int          free_n;
    logic [23:0] used_at [N_USED];
    logic [24:0] used_len [N_USED];
    int          used_n;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] address;
    } t_answer;

    t_answer pending_answers[$];
    int      fail_count = 0;
    int      quiet_cycles = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_req = 0;      // bumped by the test sequence to ask for a hold-off
    int      hold_seen = 0;
    int      hold_left = 0;

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    // Apply one request to the predicted tables and return its answer.
    function automatic t_answer allocate_predict(input logic [1:0] kind,
                                                 input logic [24:0] size,
                                                 input logic [23:0] ofs);
        t_answer a;
        int pick;
        logic [24:0] len;
        logic [23:0] at;
        a = '{status: fpba_pkg::ST_OK, address: '0};
        pick = -1;
        if (kind == fpba_pkg::KIND_INIT) begin
            len = (region_len > SPAN_MAX) ? SPAN_MAX : region_len;
            free_n = 0;
            used_n = 0;
            if (len != 0) begin
                free_at[0] = '0;
                free_len[0] = len;
                free_n = 1;
            end
        end else if (kind == fpba_pkg::KIND_ALLOC) begin
            if (size != 0) begin
                for (int i = 0; i < free_n; i++) begin
                    if (free_len[i] < size) continue;
                    if (pick < 0) begin
                        pick = i;
                        if (policy != fpba_pkg::POL_BEST && policy != fpba_pkg::POL_WORST)
                            break;
                    end else if (policy == fpba_pkg::POL_BEST
                                 && free_len[i] < free_len[pick])
                        pick = i;
                    else if (policy == fpba_pkg::POL_WORST
                             && free_len[i] > free_len[pick])
                        pick = i;
                end
            end
            if (pick < 0) a.status = fpba_pkg::ST_NOFIT;
            else if (used_n >= N_USED) a.status = fpba_pkg::ST_FULL;
            else begin
                at = free_at[pick];
                if (free_len[pick] == size) begin
                    for (int i = pick; i + 1 < free_n; i++) begin
                        free_at[i] = free_at[i + 1];
                        free_len[i] = free_len[i + 1];
                    end
                    free_n--;
                end else begin
                    free_at[pick] = at + size[23:0];
                    free_len[pick] = free_len[pick] - size;
                end
                for (int i = used_n; i > 0; i--) begin
                    used_at[i] = used_at[i - 1];
                    used_len[i] = used_len[i - 1];
                end
                used_at[0] = at;
                used_len[0] = size;
                used_n++;
                a.address = at;
            end
        end else if (kind == fpba_pkg::KIND_FREE) begin
            for (int i = 0; i < used_n; i++)
                if (used_at[i] == ofs) begin
                    pick = i;
                    break;
                end
            if (pick < 0) a.status = fpba_pkg::ST_NOTALLOC;
            else if (free_n >= N_FREE) a.status = fpba_pkg::ST_FULL;
            else begin
                at = used_at[pick];
                len = used_len[pick];
                for (int i = pick; i + 1 < used_n; i++) begin
                    used_at[i] = used_at[i + 1];
                    used_len[i] = used_len[i + 1];
                end
                used_n--;
                for (int i = free_n; i > 0; i--) begin
                    free_at[i] = free_at[i - 1];
                    free_len[i] = free_len[i - 1];
                end
                free_at[0] = at;
                free_len[0] = len;
                free_n++;
            end
        end
        return a;
    endfunction

    // Offer one request; hold it until accepted, then predict its answer.
    // Valid stays up after acceptance; the next call or a drain drops it.
    task automatic send_request(input logic [1:0] kind, input logic [24:0] size,
                                input logic [23:0] ofs);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_request_size <= size;
        i_block_offset <= ofs;
        do @(posedge i_clk); while (o_stall);
        pending_answers.push_back(allocate_predict(kind, size, ofs));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(input logic idx, input logic [24:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == fpba_pkg::CFG_POLICY) policy = value[1:0];
        else region_len = value;
    endtask

    // Receiver stall: random idling, or a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else
            i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check each accepted answer against the oldest prediction.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0)
                report("answer with no request outstanding");
            else begin
                want = pending_answers.pop_front();
                if (o_status !== want.status)
                    report($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_address !== want.address)
                    report($sformatf("address %0h, want %0h", o_address, want.address));
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** fit_policy_block_allocator: FAILED **");
            $finish;
        end
    end

    // Sizes: mostly small so the tables churn, a few at the extremes.
    function automatic logic [24:0] pick_size();
        case ($urandom_range(9))
            0: return 25'($urandom_range(SPAN_MAX));
            1: return SPAN_MAX;
            2: return 25'h1FFFFFF - 25'($urandom_range(3));
            default: return 25'($urandom_range(1, 64));
        endcase
    endfunction

    // Offsets: mostly ones that were handed out, some random.
    function automatic logic [23:0] pick_offset();
        if (used_n > 0 && $urandom_range(3) != 0)
            return used_at[$urandom_range(used_n - 1)];
        return 24'($urandom());
    endfunction

    task automatic test_directed();
        send_request(fpba_pkg::KIND_ALLOC, 25'd4, '0);
        send_request(fpba_pkg::KIND_FREE, '0, 24'hFFFFFF);
        send_request(fpba_pkg::KIND_RSVD, 25'h1FFFFFF, 24'hFFFFFF);
        send_request(fpba_pkg::KIND_INIT, '0, '0);
        send_request(fpba_pkg::KIND_ALLOC, '0, '0);
        send_request(fpba_pkg::KIND_ALLOC, SPAN_MAX, '0);
        send_request(fpba_pkg::KIND_FREE, '0, '0);
        send_request(fpba_pkg::KIND_FREE, '0, '0);
        send_request(fpba_pkg::KIND_ALLOC, SPAN_MAX + 25'd1, '0);
        send_request(fpba_pkg::KIND_ALLOC, 25'd10, '0);
        send_request(fpba_pkg::KIND_ALLOC, 25'd20, '0);
        send_request(fpba_pkg::KIND_ALLOC, 25'd30, '0);
        send_request(fpba_pkg::KIND_FREE, '0, 24'd10);
        send_request(fpba_pkg::KIND_FREE, '0, 24'd10);
        send_request(fpba_pkg::KIND_FREE, '0, 24'd0);
        send_request(fpba_pkg::KIND_ALLOC, 25'd5, '0);
        send_request(fpba_pkg::KIND_ALLOC, 25'h1FFFFFF, '0);
    endtask

    task automatic test_regions();
        write_reg(fpba_pkg::CFG_REGION, '0);
        send_request(fpba_pkg::KIND_INIT, '0, '0);
        send_request(fpba_pkg::KIND_ALLOC, 25'd1, '0);
        write_reg(fpba_pkg::CFG_REGION, 25'h1FFFFFF);
        send_request(fpba_pkg::KIND_INIT, '0, '0);
        send_request(fpba_pkg::KIND_ALLOC, SPAN_MAX, '0);
        send_request(fpba_pkg::KIND_FREE, '0, '0);
        write_reg(fpba_pkg::CFG_REGION, 25'd1);
        send_request(fpba_pkg::KIND_INIT, '0, '0);
        send_request(fpba_pkg::KIND_ALLOC, 25'd1, '0);
        send_request(fpba_pkg::KIND_ALLOC, 25'd1, '0);
    endtask

    // Fill the used table, then free blocks into the free table until it is full.
    task automatic test_table_full();
        write_reg(fpba_pkg::CFG_REGION, 25'd4096);
        write_reg(fpba_pkg::CFG_POLICY, 25'(fpba_pkg::POL_FIRST));
        send_request(fpba_pkg::KIND_INIT, '0, '0);
        for (int i = 0; i < N_USED + 2; i++)
            send_request(fpba_pkg::KIND_ALLOC, 25'd2, '0);
        for (int i = 0; i < N_USED; i++)
            send_request(fpba_pkg::KIND_FREE, '0, 24'(2 * i));
        send_request(fpba_pkg::KIND_FREE, '0, 24'd2);
    endtask

    // Random traffic for one policy; mostly alloc and free.
    task automatic test_random(input logic [1:0] pol, input int count);
        int k;
        write_reg(fpba_pkg::CFG_POLICY, 25'(pol));
        write_reg(fpba_pkg::CFG_REGION, ($urandom_range(3) == 0)
                                        ? 25'($urandom())
                                        : 25'($urandom_range(64, 4096)));
        send_request(fpba_pkg::KIND_INIT, '0, '0);
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(99);
            if (k < 2) send_request(fpba_pkg::KIND_INIT, pick_size(), pick_offset());
            else if (k < 4)
                send_request(fpba_pkg::KIND_RSVD, 25'($urandom()), 24'($urandom()));
            else if (k < 52) send_request(fpba_pkg::KIND_ALLOC, pick_size(), pick_offset());
            else send_request(fpba_pkg::KIND_FREE, pick_size(), pick_offset());
        end
    endtask

    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 6; i++) send_request(fpba_pkg::KIND_ALLOC, 25'd3, '0);
        wait_drained();
        send_request(fpba_pkg::KIND_FREE, '0, pick_offset());
    endtask

    initial begin
        policy = fpba_pkg::POL_FIRST;
        region_len = SPAN_MAX;
        free_n = 0;
        used_n = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 24;
        recv_idle_pct = 81;
        test_directed();
        test_regions();
        test_table_full();
        test_random(fpba_pkg::POL_FIRST, 150);
        test_random(fpba_pkg::POL_BEST, 150);
        send_idle_pct = 81;
        recv_idle_pct = 24;
        test_random(fpba_pkg::POL_WORST, 150);
        test_random(fpba_pkg::POL_RSVD, 100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(fpba_pkg::POL_BEST, 200);
        test_random(fpba_pkg::POL_WORST, 200);
        test_random(fpba_pkg::POL_FIRST, 150);
        wait_drained();
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("** fit_policy_block_allocator: PASSED **");
        else
            $display("** fit_policy_block_allocator: FAILED **");
        $finish;
    end
endmodule
